/* src/tmap_pkg.sv */
// ----------------------------------------------------------------------------
// tmap_pkg
// Shared types, constants and the exposure scale function for the tonemapper.
// ----------------------------------------------------------------------------
package tmap_pkg;

    localparam int DIV_STEPS  = 25;
    localparam int PIPE_DEPTH = DIV_STEPS + 3;
    localparam int TONE_FRAC  = 24;

    localparam logic [56:0] Y_SAT       = 57'(1) << 56;
    localparam logic [57:0] DEN_OFFSET  = 58'(1) << 30;
    localparam logic [4:0]  EXP_SPECIAL = 5'd31;
    localparam logic signed [10:0] K_BIAS = 11'sd19;
    localparam logic [8:0]  RST_EXPOSURE = 9'd16;

    // 2^(2^-j) in Q1.24 for j = 1..8
    localparam logic [24:0] ROOTS [8] = '{
        25'd23726566, 25'd19951585, 25'd18295684, 25'd17520007,
        25'd17144589, 25'd16959908, 25'd16868315, 25'd16822704
    };

    typedef enum logic [1:0] {
        OVR_NONE,
        OVR_ZERO,
        OVR_ONE
    } t_ovr;

    typedef struct packed {
        logic [57:0] rem;
        logic [57:0] den;
        logic [24:0] quo;
        t_ovr        ovr;
    } t_div;

    // Fractional exposure scale in Q1.24; only evaluated on constants.
    function automatic logic [24:0] scale_of(input int frac, input int fbits);
        logic [63:0] s;
        s = 64'(1) << 24;
        for (int b = 0; b < 8; b++) begin
            if (b < fbits && ((frac >> b) & 1) == 1) begin
                s = (s * 64'(ROOTS[(fbits - b - 1) & 7]) + (64'(1) << 23)) >> 24;
            end
        end
        return s[24:0];
    endfunction

endpackage

/* src/tmap_div_stage.sv */
// ----------------------------------------------------------------------------
// tmap_div_stage
// One restoring division step with its pipeline register.
// ----------------------------------------------------------------------------
module tmap_div_stage import tmap_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);

    logic [57:0] w_sh;
    logic        w_ge;
    t_div        r_d;

    assign w_sh = {i_d.rem[56:0], 1'b0};
    assign w_ge = (w_sh >= i_d.den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.rem <= w_ge ? (w_sh - i_d.den) : w_sh;
            r_d.den <= i_d.den;
            r_d.quo <= {i_d.quo[23:0], w_ge};
            r_d.ovr <= i_d.ovr;
        end
    end

    assign o_d = r_d;

endmodule

/* src/tmap_lane.sv */
// ----------------------------------------------------------------------------
// tmap_lane
// One color channel: half decode, exposure multiply, shift with saturation,
// pipelined Reinhard division and output formatting.
// ----------------------------------------------------------------------------
module tmap_lane import tmap_pkg::*; #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic [PIPE_DEPTH-1:0]   i_en,
    input  logic [15:0]             i_half,
    input  logic signed [9:0]       i_whole,
    input  logic [24:0]             i_scale,
    output logic [7:0]              o_byte,
    output logic [LEVEL_BITS-1:0]   o_level
);

    // Stage 0: decode and multiply
    logic [4:0]         w_e;
    logic [4:0]         w_e_eff;
    logic [10:0]        w_m;
    t_ovr               n_ovr;
    logic signed [10:0] n_k;
    logic [35:0]        n_p;
    logic [35:0]        r_p;
    logic signed [10:0] r_k;
    t_ovr               r_ovr;

    assign w_e     = i_half[14:10];
    assign w_e_eff = (w_e != 5'd0) ? w_e : 5'd1;
    assign w_m     = {(w_e != 5'd0), i_half[9:0]};
    assign n_k     = 11'(signed'({1'b0, w_e_eff})) + 11'(i_whole) - K_BIAS;
    assign n_p     = 36'(w_m) * 36'(i_scale);

    always_comb begin
        if (i_half[15]) begin
            n_ovr = OVR_ZERO;
        end else if (w_e == EXP_SPECIAL) begin
            n_ovr = (i_half[9:0] != 10'd0) ? OVR_ZERO : OVR_ONE;
        end else begin
            n_ovr = OVR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p   <= n_p;
            r_k   <= n_k;
            r_ovr <= n_ovr;
        end
    end

    // Stage 1: shift into Q27.30 with saturation
    logic [92:0] w_wide;
    logic [10:0] w_nk;
    logic [56:0] w_y;
    t_div        s_div [DIV_STEPS+1];
    t_div        r_div0;

    always_comb begin
        w_wide = {57'd0, r_p} << r_k[5:0];
        w_nk   = 11'(-r_k);
        w_y    = '0;
        if (r_p == 36'd0) begin
            w_y = '0;
        end else if (!r_k[10]) begin
            if (r_k >= 11'sd56 || (|w_wide[92:56])) begin
                w_y = Y_SAT;
            end else begin
                w_y = w_wide[56:0];
            end
        end else if (w_nk < 11'd36) begin
            w_y = 57'(r_p >> w_nk[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_div0.rem <= 58'(w_y);
            r_div0.den <= 58'(w_y) + DEN_OFFSET;
            r_div0.quo <= '0;
            r_div0.ovr <= r_ovr;
        end
    end

    assign s_div[0] = r_div0;

    // Division steps, one quotient bit per stage
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        tmap_div_stage u_step (
            .i_clk (i_clk),
            .i_en  (i_en[g+2]),
            .i_d   (s_div[g]),
            .o_d   (s_div[g+1])
        );
    end

    // Final stage: round, override and format
    logic [25:0]           w_q1;
    logic [24:0]           w_t;
    logic [32:0]           w_prod;
    logic [24:0]           w_lvl;
    logic [LEVEL_BITS-1:0] n_level;
    logic [7:0]            r_byte;
    logic [LEVEL_BITS-1:0] r_level;

    always_comb begin
        w_q1 = 26'(s_div[DIV_STEPS].quo) + 26'd1;
        case (s_div[DIV_STEPS].ovr)
            OVR_ZERO: w_t = '0;
            OVR_ONE:  w_t = 25'(1) << TONE_FRAC;
            default:  w_t = w_q1[25:1];
        endcase
        w_prod = {w_t, 8'd0} - 33'(w_t);
        w_lvl  = w_t >> (TONE_FRAC - LEVEL_BITS);
        if (|w_lvl[24:LEVEL_BITS]) begin
            n_level = '1;
        end else begin
            n_level = w_lvl[LEVEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STEPS+2]) begin
            r_byte  <= w_prod[31:24];
            r_level <= n_level;
        end
    end

    assign o_byte  = r_byte;
    assign o_level = r_level;

endmodule

/* src/half_rgb_exposure_reinhard_tonemap.sv */
// ----------------------------------------------------------------------------
// half_rgb_exposure_reinhard_tonemap
// Half-float RGB pixel to tonemapped bytes and levels with exposure control.
//
//   channel   direction  handshake            payload
//   pixel in  input      i_valid / o_ready    i_red/green/blue_half
//   pixel out output     o_valid / i_ready    o_*_byte, o_*_level
//   config    input      i_cfg_we             i_cfg_data (exposure)
//
// One pixel per cycle sustained while i_ready is high, through 28 register
// stages: the 25-stage restoring divider in each lane plus decode, shift and
// format stages. Synchronous reset clears all stage valid bits and loads
// exposure 16. Every full stage holds when the one after it is full and
// stalled, so bubbles are squeezed out and input is taken while a result
// waits.
// ----------------------------------------------------------------------------
module half_rgb_exposure_reinhard_tonemap import tmap_pkg::*; #(
    parameter int LEVEL_BITS         = 16,
    parameter int EXPOSURE_FRAC_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [15:0]           i_red_half,
    input  logic [15:0]           i_green_half,
    input  logic [15:0]           i_blue_half,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_red_byte,
    output logic [7:0]            o_green_byte,
    output logic [7:0]            o_blue_byte,
    output logic [LEVEL_BITS-1:0] o_red_level,
    output logic [LEVEL_BITS-1:0] o_green_level,
    output logic [LEVEL_BITS-1:0] o_blue_level,
    input  logic                  i_cfg_we,
    input  logic [8:0]            i_cfg_data
);

    localparam int FRAC_COUNT = 1 << EXPOSURE_FRAC_BITS;

    // Exposure: whole stops and fractional scale, resolved when written
    logic [24:0]        w_tbl [256];
    logic [8:0]         w_src;
    logic [8:0]         w_biased;
    logic [7:0]         w_frac;
    logic signed [9:0]  n_whole;
    logic signed [9:0]  r_whole;
    logic [24:0]        r_scale;

    for (genvar i = 0; i < 256; i++) begin : g_tbl
        localparam logic [24:0] ENTRY =
            (i < FRAC_COUNT) ? scale_of(i, EXPOSURE_FRAC_BITS) : 25'd0;
        assign w_tbl[i] = ENTRY;
    end

    assign w_src    = i_rst_n ? i_cfg_data : RST_EXPOSURE;
    assign w_biased = {~w_src[8], w_src[7:0]};
    assign w_frac   = 8'(w_biased & 9'(FRAC_COUNT - 1));
    assign n_whole  = 10'(w_biased >> EXPOSURE_FRAC_BITS) - 10'(256 >> EXPOSURE_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_whole <= n_whole;
            r_scale <= w_tbl[w_frac];
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [PIPE_DEPTH-1:0] w_en;

    always_comb begin
        w_en[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || i_ready;
        for (int s = PIPE_DEPTH - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
        n_vld = r_vld;
        for (int s = 0; s < PIPE_DEPTH; s++) begin
            if (w_en[s]) begin
                n_vld[s] = (s == 0) ? i_valid : r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[PIPE_DEPTH-1];

    tmap_lane #(.LEVEL_BITS(LEVEL_BITS)) u_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_half  (i_red_half),
        .i_whole (r_whole),
        .i_scale (r_scale),
        .o_byte  (o_red_byte),
        .o_level (o_red_level)
    );

    tmap_lane #(.LEVEL_BITS(LEVEL_BITS)) u_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_half  (i_green_half),
        .i_whole (r_whole),
        .i_scale (r_scale),
        .o_byte  (o_green_byte),
        .o_level (o_green_level)
    );

    tmap_lane #(.LEVEL_BITS(LEVEL_BITS)) u_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_half  (i_blue_half),
        .i_whole (r_whole),
        .i_scale (r_scale),
        .o_byte  (o_blue_byte),
        .o_level (o_blue_level)
    );

    // An accepted request always lands in the first stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    // Input is refused only when every stage holds an item.
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input refused while a stage was empty");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

/* verif/half_rgb_exposure_reinhard_tonemap_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_rgb_exposure_reinhard_tonemap_tb
// Self-checking bench for the half-float Reinhard tonemapper. Directed pixels
// from a table and random pixels are pushed through the block. Several
// exposure settings are used, including both extremes. Every result is compared
// with a predictor or typed-in result; bytes and levels are checked per channel.
// ----------------------------------------------------------------------------
module half_rgb_exposure_reinhard_tonemap_tb;
    import tmap_pkg::*;

    localparam int LVL = 16;
    localparam int FB = 4;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [7:0] rb, gb, bb;
        logic [15:0] rl, gl, bl;
    } t_pix_out;

    // One directed row. If has_exp is set, the typed-in result is checked instead.
    typedef struct packed {
        logic [15:0] r, g, b;
        logic has_exp;
        t_pix_out expv;
    } t_row;

    logic i_clk, i_rst_n, i_valid, i_ready, i_cfg_we;
    logic o_ready, o_valid;
    logic [15:0] i_red_half, i_green_half, i_blue_half;
    logic [8:0] i_cfg_data;
    logic [7:0] o_red_byte, o_green_byte, o_blue_byte;
    logic [LVL-1:0] o_red_level, o_green_level, o_blue_level;

    half_rgb_exposure_reinhard_tonemap #(.LEVEL_BITS(LVL), .EXPOSURE_FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_red_half(i_red_half), .i_green_half(i_green_half), .i_blue_half(i_blue_half),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_red_byte(o_red_byte), .o_green_byte(o_green_byte), .o_blue_byte(o_blue_byte),
        .o_red_level(o_red_level), .o_green_level(o_green_level),
        .o_blue_level(o_blue_level),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    int errors = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int idle_cycles = 0;
    bit quiet_stretch = 0;
    logic signed [8:0] exposure = 9'sd16;
    t_pix_out pending_pixels[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [24:0] tone_of(logic [15:0] h, int whole, logic [63:0] scale);
        logic [4:0] e;
        logic [63:0] m, p, y, den, r, q;
        int k;
        e = h[14:10];
        if (h[15]) return 0;
        if (e == 5'd31) return (h[9:0] != 0) ? 25'd0 : 25'(1 << 24);
        m = (e != 0) ? {53'd0, 1'b1, h[9:0]} : {54'd0, h[9:0]};
        k = ((e != 0) ? int'(e) : 1) + whole - 19;
        p = m * scale;
        if (p == 0) y = 0;
        else if (k >= 0) begin
            if (k >= 56 || p >= (64'd1 << (56 - k))) y = 64'd1 << 56;
            else y = p << k;
        end else y = (-k >= 64) ? 64'd0 : (p >> (-k));
        den = y + (64'd1 << 30);
        r = y;
        q = 0;
        for (int i = 0; i < 25; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return 25'((q + 1) >> 1);
    endfunction

    function automatic t_pix_out tonemap_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        logic [8:0] biased;
        int whole;
        logic [63:0] scale;
        logic [24:0] t [3];
        logic [63:0] lev;
        logic [7:0] by [3];
        logic [15:0] lv [3];
        biased = {~exposure[8], exposure[7:0]};
        whole = int'(biased >> FB) - (256 >> FB);
        scale = 64'd1 << 24;
        for (int i = 0; i < FB; i++)
            if (biased[i])
                scale = (scale * 64'(ROOTS[(FB - i - 1) & 7]) + (64'd1 << 23)) >> 24;
        t[0] = tone_of(r, whole, scale);
        t[1] = tone_of(g, whole, scale);
        t[2] = tone_of(b, whole, scale);
        for (int c = 0; c < 3; c++) begin
            lev = 64'(t[c]) >> (24 - LVL);
            if (lev > 64'hFFFF) lev = 64'hFFFF;
            by[c] = 8'((64'(t[c]) * 255) >> 24);
            lv[c] = lev[15:0];
        end
        return '{by[0], by[1], by[2], lv[0], lv[1], lv[2]};
    endfunction

    // Valid is dropped only while idling, so requests can follow back to back.
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        while (!quiet_stretch && $urandom_range(99) < 12) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_red_half <= r;
        i_green_half <= g;
        i_blue_half <= b;
        pending_pixels.push_back(tonemap_pixel(r, g, b));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic set_exposure(logic signed [8:0] v);
        i_valid <= 0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        exposure = v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [15:0] rand_half();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return {1'b0, 5'd31, 10'($urandom)};
            2: return {1'b0, 5'd0, 10'($urandom)};
            default: return {1'b0, 5'($urandom_range(30)), 10'($urandom)};
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_pix_out got, want;
            got = '{o_red_byte, o_green_byte, o_blue_byte,
                    o_red_level, o_green_level, o_blue_level};
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with no pixel pending, got %h", $time, got);
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (got.rb != want.rb || got.gb != want.gb || got.bb != want.bb ||
                    got.rl != want.rl || got.gl != want.gl || got.bl != want.bl) begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 12);

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Directed rows; the typed-in results hold for every exposure.
    t_row rows[] = '{
        '{16'h0000, 16'h8000, 16'h7C00, 1'b1, '{8'd0, 8'd0, 8'd255, 16'd0, 16'd0, 16'hFFFF}},
        '{16'h7E00, 16'hFC00, 16'hFFFF, 1'b1, '{8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0}},
        '{16'h7C01, 16'h7FFF, 16'h8001, 1'b1, '{8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0}},
        '{16'h3C00, 16'h4000, 16'h3800, 1'b0, '0},
        '{16'h0001, 16'h03FF, 16'h0400, 1'b0, '0},
        '{16'h7BFF, 16'h7800, 16'h5BFF, 1'b0, '0},
        '{16'h1234, 16'h2AAA, 16'h3555, 1'b0, '0},
        '{16'h4A00, 16'h0200, 16'h6400, 1'b0, '0}
    };

    initial begin
        logic signed [8:0] settings [5];
        settings = '{9'sd16, 9'h100, 9'sd255, 9'sd0, -9'sd37};
        i_rst_n = 0;
        i_valid = 0;
        i_cfg_we = 0;
        i_cfg_data = 0;
        i_red_half = 0;
        i_green_half = 0;
        i_blue_half = 0;
        i_ready = 1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        for (int s = 0; s < 5; s++) begin
            if (s != 0) set_exposure(settings[s]);
            foreach (rows[i]) begin
                if (rows[i].has_exp) pending_pixels.push_back(rows[i].expv);
                send_pixel(rows[i].r, rows[i].g, rows[i].b);
                if (rows[i].has_exp) void'(pending_pixels.pop_back());
            end
            for (int n = 0; n < 350; n++) begin
                quiet_stretch = (s == 2 && n < 150);
                send_pixel(rand_half(), rand_half(), rand_half());
            end
            quiet_stretch = 0;
        end
        i_valid <= 0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        $display("Sent %0d pixels over 5 exposure settings, %0d results checked.",
                 pixels_sent, pixels_checked);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
